[src/frt_pkg.sv]
// shared constants and types for the fragment reassembly table
// no dependencies
`timescale 1ns / 1ps
package frt_pkg;
	localparam int SLOTS        = 20;
	localparam int BUFFER_BYTES = 2048;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int ADDR_W       = $clog2(BUFFER_BYTES);
	localparam int MEM_DEPTH    = SLOTS * BUFFER_BYTES;
	localparam int MEM_W        = $clog2(MEM_DEPTH);
	localparam logic [11:0] LEN_MAX = 12'hFFF;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_READ   = 2'd1,
		KIND_PASS   = 2'd2
	} kind_t;

	typedef struct packed {
		logic         hit;
		logic [SLOT_W-1:0] hit_slot;
		logic         free;
		logic [SLOT_W-1:0] free_slot;
	} lookup_t;
endpackage

[src/frt_buffer.sv]
// slot byte buffer memory, one write port and one registered read port
// depends on frt_pkg
`timescale 1ns / 1ps
module frt_buffer
	import frt_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [MEM_W-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic             re,
	input  logic [MEM_W-1:0] raddr,
	output logic [7:0]       rdata
);
	logic [7:0] mem [MEM_DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[src/fragment_reassembly_table.sv]
// fragment reassembly table top level: slot table, lookup sequencer, buffer
// depends on frt_pkg and frt_buffer
// sequence: a data byte goes through ST_STORE, a read through ST_RDWAIT and
// ST_RDDATA; a stored fragment start first scans every slot (one shared
// compare unit scans a slot per cycle), then goes through ST_TAKE and ST_STORE
// one word at a time; stall high until result taken
// reset clears slot table and context; buffer contents undefined until written
`timescale 1ns / 1ps
module fragment_reassembly_table
	import frt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  frag_id,
	input  logic [7:0]  total_frags,
	input  logic [15:0] frag_offset,
	input  logic [7:0]  data_byte,
	input  logic        first_of_fragment,
	input  logic        last_of_fragment,
	input  logic [4:0]  read_slot,
	input  logic [10:0] read_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic        status,
	output logic [4:0]  slot,
	output logic [11:0] packet_length,
	output logic [7:0]  out_byte,
	output logic        done_res,
	output logic        overflow
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_TAKE, ST_STORE, ST_RDWAIT, ST_RDDATA, ST_OUT
	} state_t;

	state_t state_q;
	logic [SLOTS-1:0] busy_q;
	logic [7:0]  ident_q  [SLOTS];
	logic [7:0]  remain_q [SLOTS];
	logic [11:0] length_q [SLOTS];
	logic [SLOT_W-1:0] cur_q;
	logic [15:0] wpos_q;
	logic [11:0] fcount_q;
	logic bypass_q, ovf_q;
	lookup_t look_q;
	logic [SLOT_W-1:0] idx_q;

	// latched input word
	logic last_q, rd_ok_q;
	logic [7:0] id_q, total_q, byte_q;

	logic       we, re;
	logic [MEM_W-1:0] waddr, raddr;
	logic [7:0] rdata;

	// shared compare unit: one slot tag a cycle
	logic tag_match;
	assign tag_match = busy_q[idx_q] && (ident_q[idx_q] == id_q);

	assign in_stall = (state_q != ST_IDLE);

	// buffer address generation
	always_comb begin
		we    = (state_q == ST_STORE) && !bypass_q && (wpos_q < 16'(BUFFER_BYTES));
		waddr = MEM_W'(cur_q) * MEM_W'(BUFFER_BYTES) + MEM_W'(wpos_q[ADDR_W-1:0]);
		re    = in_valid && !in_stall && action;
		raddr = MEM_W'(read_slot[SLOT_W-1:0]) * MEM_W'(BUFFER_BYTES)
			+ MEM_W'(read_addr[ADDR_W-1:0]);
	end

	frt_buffer u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (byte_q),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequencer with slot table and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			busy_q    <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				ident_q[i]  <= '0;
				remain_q[i] <= '0;
				length_q[i] <= '0;
			end
			cur_q     <= '0;
			wpos_q    <= '0;
			fcount_q  <= '0;
			bypass_q  <= 1'b0;
			ovf_q     <= 1'b0;
			look_q    <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
			kind <= '0; status <= 1'b0; slot <= '0; packet_length <= '0;
			out_byte <= '0; done_res <= 1'b0; overflow <= 1'b0;
			last_q <= 1'b0; rd_ok_q <= 1'b0;
			id_q <= '0; total_q <= '0; byte_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q  <= last_of_fragment;
						id_q    <= frag_id;
						total_q <= total_frags;
						byte_q  <= data_byte;
						rd_ok_q <= (read_slot < 5'(SLOTS))
							&& ({1'b0, read_addr} < 12'(BUFFER_BYTES));
						look_q  <= '0;
						idx_q   <= '0;
						if (action) begin
							state_q <= ST_RDWAIT;
						end else if (first_of_fragment) begin
							fcount_q <= '0;
							ovf_q    <= 1'b0;
							wpos_q   <= frag_offset;
							if (total_frags == 8'd1) begin
								bypass_q <= 1'b1;
								state_q  <= ST_STORE;
							end else begin
								bypass_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
						end else begin
							state_q <= ST_STORE;
						end
					end
				end
				ST_SCAN: begin
					if (tag_match && !look_q.hit) begin
						look_q.hit      <= 1'b1;
						look_q.hit_slot <= idx_q;
					end
					if (!busy_q[idx_q]) begin
						look_q.free      <= 1'b1;
						look_q.free_slot <= idx_q;
					end
					if (idx_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_TAKE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_TAKE: begin
					if (look_q.hit) begin
						cur_q <= look_q.hit_slot;
						remain_q[look_q.hit_slot] <= remain_q[look_q.hit_slot] - 8'd1;
					end else begin
						if (look_q.free) begin
							cur_q <= look_q.free_slot;
							busy_q[look_q.free_slot] <= 1'b1;
							ident_q[look_q.free_slot]  <= id_q;
							remain_q[look_q.free_slot] <= total_q - 8'd1;
							length_q[look_q.free_slot] <= '0;
						end else begin
							// table full: free everything, take the top slot
							busy_q <= {1'b1, {(SLOTS-1){1'b0}}};
							cur_q <= SLOT_W'(SLOTS - 1);
							ident_q[SLOTS-1]  <= id_q;
							remain_q[SLOTS-1] <= total_q - 8'd1;
							length_q[SLOTS-1] <= '0;
						end
					end
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					if (fcount_q != LEN_MAX) begin
						fcount_q <= fcount_q + 12'd1;
					end
					if (bypass_q) begin
						kind      <= KIND_PASS;
						status    <= 1'b0;
						slot      <= '0;
						packet_length <= '0;
						out_byte  <= byte_q;
						done_res  <= last_q;
						overflow  <= 1'b0;
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end else begin
						if (wpos_q >= 16'(BUFFER_BYTES)) begin
							ovf_q <= 1'b1;
						end
						if (wpos_q != 16'hFFFF) begin
							wpos_q <= wpos_q + 16'd1;
						end
						if (length_q[cur_q] != LEN_MAX) begin
							length_q[cur_q] <= length_q[cur_q] + 12'd1;
						end
						if (last_q) begin
							kind   <= KIND_STATUS;
							status <= busy_q[cur_q] && (remain_q[cur_q] == 8'd0);
							slot   <= 5'(cur_q);
							packet_length <= (length_q[cur_q] != LEN_MAX)
								? length_q[cur_q] + 12'd1 : LEN_MAX;
							out_byte <= '0;
							done_res <= 1'b0;
							overflow <= ovf_q || (wpos_q >= 16'(BUFFER_BYTES));
							if (busy_q[cur_q] && remain_q[cur_q] == 8'd0) begin
								busy_q[cur_q] <= 1'b0;
							end
							out_valid <= 1'b1;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_RDDATA;
				end
				ST_RDDATA: begin
					kind <= KIND_READ;
					status <= 1'b0; slot <= '0; packet_length <= '0;
					done_res <= 1'b0; overflow <= 1'b0;
					out_byte  <= rd_ok_q ? rdata : 8'd0;
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
